/* design/mpad_pkg.sv */
// Shared types, widths and constants for the modular power block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mpad_pkg;

  localparam int MAX_DIGITS = 18;
  localparam int DIGIT_W    = 5;
  localparam int VAL_W      = 60;   // holds any residue below 10^18
  localparam int OPB_W      = 63;   // multiplier operand, wide enough for a raw input
  localparam int MUL_STEPS  = OPB_W;
  localparam int CNT_W      = $clog2(MUL_STEPS);

  typedef logic [VAL_W-1:0]   val_t;
  typedef logic [OPB_W-1:0]   opb_t;
  typedef logic [DIGIT_W-1:0] digit_t;

  // Request to the modular multiply unit: result = (a * b) mod m.
  typedef struct packed {
    logic start;
    val_t a;
    opb_t b;
  } mul_req_t;

  typedef struct packed {
    logic done;
    val_t result;
  } mul_rsp_t;

  // Sequencer status toward the top level.
  typedef struct packed {
    logic idle;
    logic res_valid;
    val_t res;
  } seq_stat_t;

  function automatic digit_t clamp_digits(input digit_t d);
    digit_t c;
    c = d;
    if (d == '0) begin
      c = digit_t'(1);
    end else if (d > digit_t'(MAX_DIGITS)) begin
      c = digit_t'(MAX_DIGITS);
    end
    return c;
  endfunction

  function automatic val_t pow10(input digit_t d);
    val_t v;
    case (d)
      5'd1:    v = 60'd10;
      5'd2:    v = 60'd100;
      5'd3:    v = 60'd1000;
      5'd4:    v = 60'd10000;
      5'd5:    v = 60'd100000;
      5'd6:    v = 60'd1000000;
      5'd7:    v = 60'd10000000;
      5'd8:    v = 60'd100000000;
      5'd9:    v = 60'd1000000000;
      5'd10:   v = 60'd10000000000;
      5'd11:   v = 60'd100000000000;
      5'd12:   v = 60'd1000000000000;
      5'd13:   v = 60'd10000000000000;
      5'd14:   v = 60'd100000000000000;
      5'd15:   v = 60'd1000000000000000;
      5'd16:   v = 60'd10000000000000000;
      5'd17:   v = 60'd100000000000000000;
      5'd18:   v = 60'd1000000000000000000;
      default: v = 60'd10;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* design/mpad_mulmod.sv */
// Bit-serial modular multiplier: one double-and-add step per cycle, MSB of b first.
// Depends on mpad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpad_mulmod (
  input  logic              clk,
  input  logic              rst,
  input  mpad_pkg::val_t    modulus,
  input  mpad_pkg::mul_req_t req,
  output mpad_pkg::mul_rsp_t rsp
);
  import mpad_pkg::*;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  val_t             r;
  val_t             a;
  opb_t             b;

  logic [VAL_W:0] dbl, dbl_red, add, add_red, m_ext;
  val_t           r_next;

  // r <- 2r mod m, then + a mod m when the current bit of b is set
  always_comb begin
    m_ext   = {1'b0, modulus};
    dbl     = {r, 1'b0};
    dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
    add     = dbl_red + {1'b0, a};
    add_red = (add >= m_ext) ? add - m_ext : add;
    r_next  = b[OPB_W-1] ? add_red[VAL_W-1:0] : dbl_red[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      r <= '0;
      a <= req.a;
      b <= req.b;
    end else if (busy) begin
      r <= r_next;
      b <= {b[OPB_W-2:0], 1'b0};
    end
  end

  assign rsp.done   = done;
  assign rsp.result = r;

  a_no_restart : assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("mulmod started while busy");

  a_result_reduced : assert property (@(posedge clk) disable iff (rst)
    done |-> (r < modulus))
    else $error("mulmod result not reduced");

  a_done_after_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("mulmod done without a run");

endmodule

`default_nettype wire

/* design/mpad_seq.sv */
// Sequencer for square-and-multiply: drives the shared modular multiplier
// through reduce, per-bit multiply/square, final multiply and +1. Depends on mpad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpad_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  mpad_pkg::opb_t     multiplier,
  input  mpad_pkg::opb_t     exponent,
  input  mpad_pkg::digit_t   digits,
  input  logic               take,
  input  mpad_pkg::mul_rsp_t rsp,
  output mpad_pkg::mul_req_t req,
  output mpad_pkg::val_t     modulus,
  output mpad_pkg::seq_stat_t stat
);
  import mpad_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_BIT  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_SQ   = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state, state_next;
  opb_t       e;
  val_t       a_red, acc, sq, res, mod_val;
  logic [VAL_W:0] inc;

  always_comb begin
    state_next = state;
    req.start  = 1'b0;
    req.a      = acc;
    req.b      = OPB_W'(sq);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          // reduce A by multiplying with one
          req.start  = 1'b1;
          req.a      = val_t'(1);
          req.b      = multiplier;
          state_next = S_RED;
        end
      end
      S_RED: begin
        if (rsp.done) state_next = S_BIT;
      end
      S_BIT: begin
        req.start = 1'b1;
        if (e == '0) begin
          req.a      = a_red;
          req.b      = OPB_W'(acc);
          state_next = S_FIN;
        end else if (e[0]) begin
          state_next = S_ACC;
        end else begin
          req.a      = sq;
          state_next = S_SQ;
        end
      end
      S_ACC: begin
        if (rsp.done) begin
          req.start  = 1'b1;
          req.a      = sq;
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        if (rsp.done) state_next = S_BIT;
      end
      S_FIN: begin
        if (rsp.done) state_next = S_OUT;
      end
      S_OUT: begin
        if (take) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    // S_ACC squares with the fresh sq operand, not acc
    if (state == S_ACC) req.b = OPB_W'(sq);
  end

  assign inc = {1'b0, rsp.result} + (VAL_W + 1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          e       <= exponent;
          mod_val <= pow10(digits);
        end
      end
      S_RED: begin
        if (rsp.done) begin
          a_red <= rsp.result;
          acc   <= val_t'(1);
          sq    <= val_t'(2);
        end
      end
      S_ACC: begin
        if (rsp.done) acc <= rsp.result;
      end
      S_SQ: begin
        if (rsp.done) begin
          sq <= rsp.result;
          e  <= {1'b0, e[OPB_W-1:1]};
        end
      end
      S_FIN: begin
        if (rsp.done) begin
          res <= (inc >= {1'b0, mod_val}) ? VAL_W'(inc - {1'b0, mod_val}) : VAL_W'(inc);
        end
      end
      default: begin
      end
    endcase
  end

  assign modulus        = mod_val;
  assign stat.idle      = (state == S_IDLE);
  assign stat.res_valid = (state == S_OUT);
  assign stat.res       = res;

  a_operands_reduced : assert property (@(posedge clk) disable iff (rst)
    (state == S_BIT) |-> (acc < mod_val) && (sq < mod_val) && (a_red < mod_val))
    else $error("working values not reduced");

  a_exp_shifts : assert property (@(posedge clk) disable iff (rst)
    (state == S_SQ) && rsp.done |=> (e == {1'b0, $past(e[OPB_W-1:1])}))
    else $error("exponent did not advance");

  a_result_reduced : assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (res < mod_val))
    else $error("residue not reduced");

endmodule

`default_nettype wire

/* design/mod_pow_affine_decimal_core.sv */
// Top level: (A * 2^B + 1) mod 10^n with config register, input/output handshakes.
// Depends on mpad_pkg, mpad_mulmod, mpad_seq.
`timescale 1ns / 1ps
`default_nettype none

// Returns the last n decimal digits of multiplier * 2^exponent + 1, with n taken
// from digit_count (0 reads as 1, above 18 reads as 18). One item is worked at a
// time; in_stall stays high until its result is handed to the output register.
// All arithmetic runs on a single bit-serial modular multiplier; each product
// takes 63 double-and-add steps before done is raised. The sequencer visits its
// bit state once per exponent bit and once more to start the final multiply. An
// item needs one product to reduce A, one square per exponent bit, one multiply
// per set bit and a final multiply by A, so the bit length of the exponent and
// its count of set bits decide how many products run. The next item can be
// accepted in the cycle out_valid rises. The worst case is an all-ones 63-bit
// exponent.
module mod_pow_affine_decimal_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mpad_pkg::opb_t       multiplier,
  input  mpad_pkg::opb_t       exponent,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mpad_pkg::val_t       residue,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  mpad_pkg::digit_t     digit_count
);
  import mpad_pkg::*;

  digit_t    dc;
  mul_req_t  req;
  mul_rsp_t  rsp;
  val_t      modulus;
  seq_stat_t stat;
  logic      in_fire, take;

  assign cfg_ready = 1'b1;
  assign in_stall  = !stat.idle;
  assign in_fire   = in_valid && stat.idle;
  // load the output register when it is empty or being drained this cycle
  assign take      = stat.res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      dc <= digit_t'(10);
    end else if (cfg_valid && cfg_ready) begin
      dc <= digit_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) residue <= stat.res;
  end

  mpad_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (in_fire),
    .multiplier (multiplier),
    .exponent   (exponent),
    .digits     (clamp_digits(dc)),
    .take       (take),
    .rsp        (rsp),
    .req        (req),
    .modulus    (modulus),
    .stat       (stat)
  );

  mpad_mulmod u_mul (
    .clk     (clk),
    .rst     (rst),
    .modulus (modulus),
    .req     (req),
    .rsp     (rsp)
  );

  a_one_item : assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !stat.idle)
    else $error("accepted item did not start");

  a_take_loads : assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid && (residue == $past(stat.res)))
    else $error("result not loaded");

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(residue))
    else $error("pending result overwritten");

endmodule

`default_nettype wire
